// File: rtl/core/dsc_pkg.sv
// Shared types and constants for the digraph strong connectivity block.
// Depends on nothing; used by every module under rtl/core.
package dsc_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int CMD_W            = 2;
	localparam int VERTEX_W         = 6;
	localparam int COUNT_W          = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_EVAL  = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ADJ_CLEAR,
		ADJ_IDLE,
		ADJ_WR_A,
		ADJ_WR_B
	} adj_state_t;

	typedef enum logic [2:0] {
		WK_IDLE,
		WK_SEED,
		WK_POP,
		WK_STK,
		WK_ROW,
		WK_SCAN,
		WK_CHECK
	} walk_state_t;

	// edge store request from the command decoder
	typedef struct packed {
		logic clear;
		logic add;
		logic both;
	} adj_cmd_t;

	// walk engine status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
		logic connected;
	} walk_status_t;

endpackage

// File: rtl/core/dsc_adj.sv
// Adjacency matrix store: one row per vertex in a synchronous memory, with
// the clearing sweep and the read-modify-write of edge adds. Uses dsc_pkg.
module dsc_adj #(
	parameter int MAX_VERTICES = dsc_pkg::MAX_VERTICES_DEF,
	localparam int VW = $clog2(MAX_VERTICES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dsc_pkg::adj_cmd_t       cmd,
	input  logic [VW-1:0]           from_addr,
	input  logic [VW-1:0]           to_addr,
	input  logic                    walk_rd_en,
	input  logic [VW-1:0]           walk_rd_addr,
	output logic [MAX_VERTICES-1:0] row_data,
	output logic                    busy
);

	localparam logic [VW-1:0] LAST_ROW = VW'(MAX_VERTICES - 1);

	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_q;

	dsc_pkg::adj_state_t state_q, state_d;
	logic [VW-1:0] sweep_q;
	logic [VW-1:0] a_q, b_q;
	logic          both_q;

	logic                    rd_en;
	logic [VW-1:0]           rd_addr;
	logic                    wr_en;
	logic [VW-1:0]           wr_addr;
	logic [MAX_VERTICES-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			row_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsc_pkg::ADJ_CLEAR: begin
				if (sweep_q == LAST_ROW) begin
					state_d = dsc_pkg::ADJ_IDLE;
				end
			end
			dsc_pkg::ADJ_IDLE: begin
				if (cmd.clear) begin
					state_d = dsc_pkg::ADJ_CLEAR;
				end else if (cmd.add) begin
					state_d = dsc_pkg::ADJ_WR_A;
				end
			end
			dsc_pkg::ADJ_WR_A: begin
				// a self loop needs no second write
				if (both_q && (a_q != b_q)) begin
					state_d = dsc_pkg::ADJ_WR_B;
				end else begin
					state_d = dsc_pkg::ADJ_IDLE;
				end
			end
			dsc_pkg::ADJ_WR_B: begin
				state_d = dsc_pkg::ADJ_IDLE;
			end
			default: begin
				state_d = dsc_pkg::ADJ_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = walk_rd_addr;
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = '0;
		unique case (state_q)
			dsc_pkg::ADJ_CLEAR: begin
				wr_en = 1'b1;
			end
			dsc_pkg::ADJ_IDLE: begin
				if (cmd.add) begin
					rd_en   = 1'b1;
					rd_addr = from_addr;
				end else begin
					rd_en   = walk_rd_en;
				end
			end
			dsc_pkg::ADJ_WR_A: begin
				wr_en   = 1'b1;
				wr_addr = a_q;
				wr_data = row_q | (MAX_VERTICES'(1) << b_q);
				// fetch the reverse row now; it is a different entry
				rd_en   = 1'b1;
				rd_addr = b_q;
			end
			dsc_pkg::ADJ_WR_B: begin
				wr_en   = 1'b1;
				wr_addr = b_q;
				wr_data = row_q | (MAX_VERTICES'(1) << a_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsc_pkg::ADJ_CLEAR;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dsc_pkg::ADJ_CLEAR) begin
				sweep_q <= (sweep_q == LAST_ROW) ? '0 : sweep_q + VW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == dsc_pkg::ADJ_IDLE) && cmd.add) begin
			a_q    <= from_addr;
			b_q    <= to_addr;
			both_q <= cmd.both;
		end
	end

	assign row_data = row_q;
	assign busy     = (state_q != dsc_pkg::ADJ_IDLE);

endmodule

// File: rtl/core/dsc_walk.sv
// Depth-first walk engine: explicit stack in a synchronous memory, visited
// marks, and the per-start reachability check. Uses dsc_pkg.
module dsc_walk #(
	parameter int MAX_VERTICES = dsc_pkg::MAX_VERTICES_DEF,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int NW = ($clog2(MAX_VERTICES + 1) > dsc_pkg::COUNT_W) ?
		$clog2(MAX_VERTICES + 1) : dsc_pkg::COUNT_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [NW-1:0]           n,
	input  logic [MAX_VERTICES-1:0] row_data,
	output logic                    rd_en,
	output logic [VW-1:0]           rd_addr,
	output dsc_pkg::walk_status_t   status
);

	localparam int SW = $clog2(MAX_VERTICES + 1);

	logic [VW-1:0] stk [MAX_VERTICES];
	logic [VW-1:0] stk_q;
	logic          stk_we, stk_re;
	logic [VW-1:0] stk_wa, stk_ra, stk_wd;

	dsc_pkg::walk_state_t state_q, state_d;
	logic [NW-1:0]           n_q, start_q;
	logic [SW-1:0]           sp_q, sp_dec;
	logic [MAX_VERTICES-1:0] visited_q, pending_q, mask_q;
	logic [MAX_VERTICES-1:0] mask_d, low_oh;
	logic [VW-1:0]           low_idx;
	logic                    done_q, connected_q;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_q <= stk[stk_ra];
		end
	end

	assign sp_dec = sp_q - SW'(1);
	assign low_oh = pending_q & (~pending_q + MAX_VERTICES'(1));

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (low_oh[i]) begin
				low_idx = low_idx | VW'(i);
			end
		end
	end

	always_comb begin
		for (int u = 0; u < MAX_VERTICES; u++) begin
			mask_d[u] = (NW'(u) < n);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsc_pkg::WK_IDLE:  if (go) state_d = dsc_pkg::WK_SEED;
			dsc_pkg::WK_SEED:  state_d = (n_q == '0) ? dsc_pkg::WK_IDLE : dsc_pkg::WK_POP;
			dsc_pkg::WK_POP:   state_d = (sp_q == '0) ? dsc_pkg::WK_CHECK : dsc_pkg::WK_STK;
			dsc_pkg::WK_STK:   state_d = dsc_pkg::WK_ROW;
			dsc_pkg::WK_ROW:   state_d = dsc_pkg::WK_SCAN;
			dsc_pkg::WK_SCAN:  if (pending_q == '0) state_d = dsc_pkg::WK_POP;
			dsc_pkg::WK_CHECK: begin
				if ((visited_q != mask_q) || ((start_q + NW'(1)) == n_q)) begin
					state_d = dsc_pkg::WK_IDLE;
				end else begin
					state_d = dsc_pkg::WK_SEED;
				end
			end
			default: state_d = dsc_pkg::WK_IDLE;
		endcase
	end

	always_comb begin
		stk_we  = 1'b0;
		stk_wa  = sp_q[VW-1:0];
		stk_wd  = low_idx;
		stk_re  = 1'b0;
		stk_ra  = sp_dec[VW-1:0];
		rd_en   = 1'b0;
		rd_addr = stk_q;
		unique case (state_q)
			dsc_pkg::WK_SEED: begin
				stk_we = (n_q != '0);
				stk_wa = '0;
				stk_wd = VW'(start_q);
			end
			dsc_pkg::WK_POP: begin
				stk_re = (sp_q != '0);
			end
			dsc_pkg::WK_STK: begin
				rd_en = 1'b1;
			end
			dsc_pkg::WK_SCAN: begin
				stk_we = (pending_q != '0);
			end
			default: begin
				stk_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsc_pkg::WK_IDLE;
			done_q      <= 1'b0;
			connected_q <= 1'b0;
			n_q         <= '0;
			start_q     <= '0;
			sp_q        <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				dsc_pkg::WK_IDLE: begin
					if (go) begin
						n_q     <= n;
						start_q <= '0;
					end
				end
				dsc_pkg::WK_SEED: begin
					if (n_q == '0) begin
						done_q      <= 1'b1;
						connected_q <= 1'b1;
					end else begin
						sp_q <= SW'(1);
					end
				end
				dsc_pkg::WK_POP: begin
					if (sp_q != '0) begin
						sp_q <= sp_dec;
					end
				end
				dsc_pkg::WK_SCAN: begin
					if (pending_q != '0) begin
						sp_q <= sp_q + SW'(1);
					end
				end
				dsc_pkg::WK_CHECK: begin
					if (visited_q != mask_q) begin
						done_q      <= 1'b1;
						connected_q <= 1'b0;
					end else if ((start_q + NW'(1)) == n_q) begin
						done_q      <= 1'b1;
						connected_q <= 1'b1;
					end else begin
						start_q <= start_q + NW'(1);
					end
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// vertex sets of the walk in progress
	always_ff @(posedge clk) begin
		case (state_q)
			dsc_pkg::WK_IDLE: begin
				if (go) begin
					mask_q <= mask_d;
				end
			end
			dsc_pkg::WK_SEED: begin
				visited_q <= MAX_VERTICES'(1) << start_q;
			end
			dsc_pkg::WK_ROW: begin
				pending_q <= row_data & ~visited_q & mask_q;
			end
			dsc_pkg::WK_SCAN: begin
				visited_q <= visited_q | low_oh;
				pending_q <= pending_q & ~low_oh;
			end
			default: begin
				pending_q <= pending_q;
			end
		endcase
	end

	assign status.busy      = (state_q != dsc_pkg::WK_IDLE);
	assign status.done      = done_q;
	assign status.connected = connected_q;

endmodule

// File: rtl/core/digraph_strong_connectivity.sv
// Clear holds busy while it sweeps the matrix, one matrix row a cycle. An add of an edge
// writes the source row, then the target row if the reverse edge is asked for and is no
// self loop. Evaluate walks from each start vertex in turn and stops at the first miss;
// then done pulses for one cycle. Throughput: one item at a time; start is taken only
// while busy is low. Reset: asynchronous, active low; the matrix is then swept to zero
// with busy high. Results cannot be stalled by the receiver.
module digraph_strong_connectivity #(
	parameter int MAX_VERTICES = dsc_pkg::MAX_VERTICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: number of vertices in use
	input  logic                         vertex_count_we,
	input  logic [dsc_pkg::COUNT_W-1:0]  vertex_count,
	// command item
	input  logic                         start,
	output logic                         busy,
	input  logic [dsc_pkg::CMD_W-1:0]    command,
	input  logic [dsc_pkg::VERTEX_W-1:0] from_vertex,
	input  logic [dsc_pkg::VERTEX_W-1:0] to_vertex,
	input  logic                         both_ways,
	// result item, evaluate only
	output logic                         done,
	output logic                         connected
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = ($clog2(MAX_VERTICES + 1) > dsc_pkg::COUNT_W) ?
		$clog2(MAX_VERTICES + 1) : dsc_pkg::COUNT_W;

	logic [dsc_pkg::COUNT_W-1:0] vertex_count_q;
	logic [NW-1:0]               n_eff;
	logic                        accept;
	logic                        edge_ok;
	logic                        eval_go;
	logic                        adj_busy;
	logic                        walk_rd_en;
	logic [VW-1:0]               walk_rd_addr;
	logic [MAX_VERTICES-1:0]     row_data;
	dsc_pkg::adj_cmd_t           adj_cmd;
	dsc_pkg::walk_status_t       walk_status;

	// Hold the vertex count; the user changes it only while the block is idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (vertex_count_we) begin
			vertex_count_q <= vertex_count;
		end
	end

	// A count above capacity acts as full capacity.
	assign n_eff = (NW'(vertex_count_q) > NW'(MAX_VERTICES)) ?
		NW'(MAX_VERTICES) : NW'(vertex_count_q);

	// Drop an edge whose either end lies outside the vertices in use.
	assign edge_ok = (NW'(from_vertex) < n_eff) && (NW'(to_vertex) < n_eff);

	assign accept = start && !busy;

	// Decode the command; the unused code does nothing.
	always_comb begin
		adj_cmd.clear = 1'b0;
		adj_cmd.add   = 1'b0;
		adj_cmd.both  = both_ways;
		eval_go       = 1'b0;
		unique case (command)
			dsc_pkg::CMD_CLEAR: adj_cmd.clear = accept;
			dsc_pkg::CMD_ADD:   adj_cmd.add   = accept && edge_ok;
			dsc_pkg::CMD_EVAL:  eval_go       = accept;
			default:            eval_go       = 1'b0;
		endcase
	end

	// Matrix rows: clearing sweep, edge read-modify-write, walk row reads.
	dsc_adj #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_adj (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (adj_cmd),
		.from_addr    (VW'(from_vertex)),
		.to_addr      (VW'(to_vertex)),
		.walk_rd_en   (walk_rd_en),
		.walk_rd_addr (walk_rd_addr),
		.row_data     (row_data),
		.busy         (adj_busy)
	);

	// Walk from every start vertex in turn; stop at the first miss.
	dsc_walk #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (eval_go),
		.n        (n_eff),
		.row_data (row_data),
		.rd_en    (walk_rd_en),
		.rd_addr  (walk_rd_addr),
		.status   (walk_status)
	);

	assign busy      = adj_busy || walk_status.busy;
	assign done      = walk_status.done;
	assign connected = walk_status.connected;

endmodule

// File: rtl/core/dsc_check.sv
// Port-level checker for the strong connectivity block, with its bind.
// Depends on dsc_pkg and on the top level digraph_strong_connectivity.
module dsc_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [dsc_pkg::CMD_W-1:0] command,
	input logic                      done
);

	// an accepted evaluate occupies the block
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == dsc_pkg::CMD_EVAL) |=> busy)
		else $error("evaluate accepted without going busy");

	// an accepted clear occupies the block for its sweep
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == dsc_pkg::CMD_CLEAR) |=> busy)
		else $error("clear accepted without going busy");

	// the result comes out as the block frees up
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a result arrives only at the end of a busy evaluation
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding evaluation");

	// one result item per evaluation, one cycle wide
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

endmodule

bind digraph_strong_connectivity dsc_check u_dsc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.command   (command),
	.done      (done)
);

// File: tb/dsc_checker.sv
// Checker for digraph_strong_connectivity: watches the command, configuration and result ports.
// Keeps its own copy of the edge matrix and vertex count, predicts every verdict, compares it.
// Depends on dsc_pkg for widths and command codes.
module dsc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vertex_count_we,
	input  logic [dsc_pkg::COUNT_W-1:0]  vertex_count,
	input  logic                         start,
	input  logic                         busy,
	input  logic [dsc_pkg::CMD_W-1:0]    command,
	input  logic [dsc_pkg::VERTEX_W-1:0] from_vertex,
	input  logic [dsc_pkg::VERTEX_W-1:0] to_vertex,
	input  logic                         both_ways,
	input  logic                         done,
	input  logic                         connected,
	output int                           fail_count,
	output int                           awaited
);
	timeunit 1ns;
	timeprecision 1ps;
	import dsc_pkg::*;

	localparam int CAP = MAX_VERTICES_DEF;

	logic [CAP-1:0]     succ_rows [CAP];
	logic [COUNT_W-1:0] count_copy;
	bit                 verdict_q [$];
	int                 mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	function automatic int live_count();
		return (int'(count_copy) > CAP) ? CAP : int'(count_copy);
	endfunction

	// set of vertices below n reachable from origin
	function automatic logic [CAP-1:0] reach_set(input int origin, input int n);
		logic [CAP-1:0] in_use;
		logic [CAP-1:0] seen;
		logic [CAP-1:0] frontier;
		logic [CAP-1:0] grown;
		in_use = '0;
		for (int i = 0; i < n; i++)
			in_use[i] = 1'b1;
		seen = '0;
		seen[origin] = 1'b1;
		frontier = seen;
		while (frontier != '0) begin
			grown = '0;
			for (int v = 0; v < CAP; v++)
				if (frontier[v])
					grown |= succ_rows[v];
			grown &= in_use & ~seen;
			seen |= grown;
			frontier = grown;
		end
		return seen;
	endfunction

	// strongly connected iff every vertex reaches all n; empty graph counts as connected
	function automatic bit strongly_connected(input int n);
		logic [CAP-1:0] in_use;
		in_use = '0;
		for (int i = 0; i < n; i++)
			in_use[i] = 1'b1;
		for (int s = 0; s < n; s++)
			if (reach_set(s, n) != in_use)
				return 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		int n;
		if (!arst_n) begin
			for (int v = 0; v < CAP; v++)
				succ_rows[v] = '0;
			count_copy = '0;
			verdict_q.delete();
			awaited <= 0;
		end else begin
			// retire the oldest verdict first; a new evaluate may be taken at the same edge
			if (done) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("result connected=%b with no evaluate pending",
						connected));
				end else begin
					want = verdict_q.pop_front();
					if (connected !== want)
						report_mismatch($sformatf("connected: got %b, want %b",
							connected, want));
				end
			end
			if (start && !busy) begin
				n = live_count();
				case (command)
					CMD_CLEAR: begin
						for (int v = 0; v < CAP; v++)
							succ_rows[v] = '0;
					end
					CMD_ADD: begin
						if (int'(from_vertex) < n && int'(to_vertex) < n) begin
							succ_rows[from_vertex][to_vertex] = 1'b1;
							if (both_ways)
								succ_rows[to_vertex][from_vertex] = 1'b1;
						end
					end
					CMD_EVAL: verdict_q.push_back(strongly_connected(n));
					default: ;
				endcase
			end
			// a count written at this edge applies from the next item on
			if (vertex_count_we)
				count_copy = vertex_count;
			awaited <= verdict_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the digraph_strong_connectivity testbench: clock, reset, command stimulus, verdict.
// Depends on dsc_pkg, the block itself and dsc_checker, which does all prediction and checking.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dsc_pkg::*;

	// the one command code the package leaves unnamed; the block ignores it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CAP          = MAX_VERTICES_DEF;
	localparam int RANDOM_ITEMS = 1100;
	// longest no-result command (clear) plus margin, used before register writes and at the end
	localparam int SETTLE_CYCLES = CAP + 8;
	// cycle limit for the whole run, set well above the slowest correct run
	localparam int CYCLE_LIMIT = 4_000_000;

	logic                clk;
	logic                arst_n;
	logic                vertex_count_we;
	logic [COUNT_W-1:0]  vertex_count;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    command;
	logic [VERTEX_W-1:0] from_vertex;
	logic [VERTEX_W-1:0] to_vertex;
	logic                both_ways;
	logic                done;
	logic                connected;
	int                  fail_count;
	int                  awaited;

	int burst_left   = 0;
	int live_n       = 0;
	int random_items = 0;
	int cycles       = 0;

	logic [CMD_W-1:0] noise_cmds [4] = '{CMD_CLEAR, CMD_ADD, CMD_EVAL, CMD_UNUSED};

	digraph_strong_connectivity dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.vertex_count_we (vertex_count_we),
		.vertex_count    (vertex_count),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.both_ways       (both_ways),
		.done            (done),
		.connected       (connected)
	);

	dsc_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.vertex_count_we (vertex_count_we),
		.vertex_count    (vertex_count),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.from_vertex     (from_vertex),
		.to_vertex       (to_vertex),
		.both_ways       (both_ways),
		.done            (done),
		.connected       (connected),
		.fail_count      (fail_count),
		.awaited         (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: a hung block or a lost result ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycles, awaited);
			$display("digraph_strong_connectivity verification failed");
			$finish;
		end
	end

	// Present one item at the falling edge and hold it until the block takes it.
	// The sender works in bursts; between bursts drop start for a random gap, which lands
	// on whatever the block happens to be doing (clear sweep, edge write, walk).
	task automatic issue_item(input logic [CMD_W-1:0] cmd, input int src, input int dst,
		input bit two_way);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start       <= 1'b1;
		command     <= cmd;
		from_vertex <= src[VERTEX_W-1:0];
		to_vertex   <= dst[VERTEX_W-1:0];
		both_ways   <= two_way;
		do @(posedge clk); while (busy);
		// ignored items do not advance the stimulus budget
		if (cmd != CMD_UNUSED && (cmd != CMD_ADD || (src < live_n && dst < live_n)))
			random_items++;
	endtask

	// Drop start and let the block drain: all verdicts back, then the longest silent command.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (awaited != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_count(input int value);
		drain();
		@(negedge clk);
		vertex_count_we <= 1'b1;
		vertex_count    <= value[COUNT_W-1:0];
		@(negedge clk);
		vertex_count_we <= 1'b0;
		live_n = (value > CAP) ? CAP : value;
	endtask

	// Well-formed sequence: optionally clear, lay a directed ring or a two-way chain over a
	// random ordering of the live vertices (sometimes minus one link), sprinkle extra and
	// out-of-range edges, then evaluate.
	task automatic build_and_check(input bit fresh);
		int order [CAP];
		int j;
		int tmp;
		int drop;
		bit chain;
		if (fresh)
			issue_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
				1'($urandom_range(0, 1)));
		for (int i = 0; i < live_n; i++)
			order[i] = i;
		for (int i = live_n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		chain = 1'($urandom_range(0, 1));
		drop  = ($urandom_range(0, 2) == 0 && live_n > 0) ? $urandom_range(0, live_n - 1) : -1;
		for (int k = 0; k < live_n; k++) begin
			if (k != drop) begin
				if (!chain)
					issue_item(CMD_ADD, order[k], order[(k + 1) % live_n], 1'b0);
				else if (k < live_n - 1)
					issue_item(CMD_ADD, order[k], order[k + 1], 1'b1);
			end
		end
		if (live_n > 0) begin
			repeat ($urandom_range(0, 4))
				issue_item(CMD_ADD, $urandom_range(0, live_n - 1),
					$urandom_range(0, live_n - 1), 1'($urandom_range(0, 1)));
		end
		// an edge touching an unused vertex must leave the matrix alone
		if (live_n < CAP && $urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 1))
				issue_item(CMD_ADD, $urandom_range(live_n, 63), $urandom_range(0, 63), 1'b1);
			else
				issue_item(CMD_ADD, $urandom_range(0, 63), $urandom_range(live_n, 63), 1'b1);
		end
		issue_item(CMD_EVAL, $urandom_range(0, 63), $urandom_range(0, 63),
			1'($urandom_range(0, 1)));
	endtask

	// Noise: any command, fields often in range. Large graphs get no extra evaluates,
	// since a connected 64-vertex walk is the slowest thing the block does.
	task automatic noise_item(input bit large_graph);
		logic [CMD_W-1:0] cmd;
		cmd = noise_cmds[$urandom_range(0, 3)];
		if (large_graph && cmd == CMD_EVAL)
			cmd = CMD_ADD;
		if (live_n > 0 && $urandom_range(0, 1))
			issue_item(cmd, $urandom_range(0, live_n - 1), $urandom_range(0, live_n - 1),
				1'($urandom_range(0, 1)));
		else
			issue_item(cmd, $urandom_range(0, 63), $urandom_range(0, 63),
				1'($urandom_range(0, 1)));
	endtask

	initial begin
		int phase;
		int setting;
		int pick;
		int sequences;
		bit large_graph;

		arst_n          = 1'b0;
		vertex_count_we = 1'b0;
		vertex_count    = '0;
		start           = 1'b0;
		command         = CMD_CLEAR;
		from_vertex     = '0;
		to_vertex       = '0;
		both_ways       = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// ---- directed part ----
		// no vertices: always connected, every edge is out of range
		set_count(0);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		issue_item(CMD_ADD, 0, 0, 1'b1);
		issue_item(CMD_EVAL, 63, 63, 1'b1);
		// single vertex, with and without a self loop
		set_count(1);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		issue_item(CMD_ADD, 0, 0, 1'b1);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		// two vertices: one way, repeated edge, both ways, clear, out of range, unused code
		set_count(2);
		issue_item(CMD_ADD, 0, 1, 1'b0);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		issue_item(CMD_ADD, 0, 1, 1'b0);
		issue_item(CMD_ADD, 1, 0, 1'b0);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		issue_item(CMD_CLEAR, 63, 63, 1'b1);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		issue_item(CMD_ADD, 1, 0, 1'b1);
		issue_item(CMD_ADD, 1, 1, 1'b0);
		issue_item(CMD_ADD, 63, 0, 1'b1);
		issue_item(CMD_ADD, 1, 63, 1'b1);
		issue_item(CMD_UNUSED, 63, 63, 1'b1);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		// grow the count over kept edges: the new vertex is isolated until linked
		set_count(3);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		issue_item(CMD_ADD, 2, 1, 1'b1);
		issue_item(CMD_EVAL, 0, 0, 1'b0);
		// full size, highest vertex index
		set_count(CAP);
		issue_item(CMD_ADD, 63, 0, 1'b1);
		issue_item(CMD_EVAL, 63, 0, 1'b1);

		// ---- random part: phases of one vertex count each ----
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (phase)
				2: setting = CAP;
				5: setting = (1 << COUNT_W) - 1;
				8: setting = $urandom_range(CAP + 1, (1 << COUNT_W) - 2);
				default: begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						setting = $urandom_range(0, 1);
					else if (pick == 1)
						setting = $urandom_range(13, 24);
					else
						setting = $urandom_range(2, 12);
				end
			endcase
			set_count(setting);
			large_graph = (live_n > 24);
			sequences = large_graph ? 2 : $urandom_range(2, 5);
			for (int s = 0; s < sequences; s++) begin
				// the first sequence of a phase sometimes keeps edges from the old count
				build_and_check(s != 0 || $urandom_range(0, 2) != 0);
				repeat ($urandom_range(0, large_graph ? 3 : 6))
					noise_item(large_graph);
			end
			phase++;
		end

		// ---- wind down: all verdicts back, then a quiet stretch for stray strobes ----
		drain();
		if (fail_count == 0)
			$display("digraph_strong_connectivity verification clean");
		else
			$display("digraph_strong_connectivity verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/dsc_pkg.sv
rtl/core/dsc_adj.sv
rtl/core/dsc_walk.sv
rtl/core/digraph_strong_connectivity.sv
rtl/core/dsc_check.sv
tb/dsc_checker.sv
tb/tb_top.sv
